/* rtl/ycta_pkg.sv */
`timescale 1ns / 1ps

package ycta_pkg;

    localparam int unsigned QC = 18;

    typedef logic [18:0] t_coef;
    typedef logic [16:0] t_q17;
    typedef logic [3:0]  t_cfg_idx;

    localparam t_cfg_idx CFG_SAMPLE_DEPTH  = 4'd0;
    localparam t_cfg_idx CFG_ALPHA_PRESENT = 4'd1;

    localparam logic [3:0] DEPTH_SEL_RESET = 4'd7;
    localparam logic [3:0] DEPTH_SEL_MAX   = 4'd15;

    localparam t_q17 ONE_Q16  = 17'd65536;
    localparam t_q17 HALF_Q16 = 17'd32768;

    localparam logic [63:0] FOOT_L      = (64'd16 * 64'd65536) / 64'd255;
    localparam logic [63:0] KS_LUMA_L   = (64'd255 << QC) / 64'd219;
    localparam logic [63:0] KS_CHROMA_L = (64'd255 << QC) / 64'd224;
    localparam logic [63:0] KRV_L = ((64'd2 * 64'd7874) << QC) / 64'd10000;
    localparam logic [63:0] KBU_L = ((64'd2 * 64'd9278) << QC) / 64'd10000;
    localparam logic [63:0] KGR_L = ((64'd2 * 64'd2126 * 64'd7874) << QC) / 64'd71520000;
    localparam logic [63:0] KGB_L = ((64'd2 * 64'd722 * 64'd9278) << QC) / 64'd71520000;

    localparam t_q17  FOOT      = FOOT_L[16:0];
    localparam t_coef KS_LUMA   = KS_LUMA_L[18:0];
    localparam t_coef KS_CHROMA = KS_CHROMA_L[18:0];
    localparam t_coef KRV       = KRV_L[18:0];
    localparam t_coef KBU       = KBU_L[18:0];
    localparam t_coef KGR       = KGR_L[18:0];
    localparam t_coef KGB       = KGB_L[18:0];

    localparam logic [63:0] TWO_32 = 64'd1 << 32;

    // floor(2^32 / (2^d - 1)) for d = 1..16
    localparam logic [32:0] RECIP [16] = '{
        33'(TWO_32 / 64'd1),     33'(TWO_32 / 64'd3),
        33'(TWO_32 / 64'd7),     33'(TWO_32 / 64'd15),
        33'(TWO_32 / 64'd31),    33'(TWO_32 / 64'd63),
        33'(TWO_32 / 64'd127),   33'(TWO_32 / 64'd255),
        33'(TWO_32 / 64'd511),   33'(TWO_32 / 64'd1023),
        33'(TWO_32 / 64'd2047),  33'(TWO_32 / 64'd4095),
        33'(TWO_32 / 64'd8191),  33'(TWO_32 / 64'd16383),
        33'(TWO_32 / 64'd32767), 33'(TWO_32 / 64'd65535)
    };

endpackage

/* rtl/ycbcr_to_argb_pixel_top.sv */
`timescale 1ns / 1ps

// BT.709 limited-range Y'CbCr (plus optional alpha) to 8-bit ARGB, one pixel per clock while o_stall is low.
// A pixel passes five register stages from acceptance to o_valid: reciprocal multiply by the depth
// maximum, quotient correction, range expansion, matrix multiply, and sum with clamp,
// each in a register stage of its own. Empty stages close up while the output is stalled,
// so o_stall rises only when all five stages hold a pixel and i_stall is high.
// sample_depth (index 0) and alpha_present (index 1) are written through the cfg port,
// which is always ready; write them only while no pixel is in flight.
module ycbcr_to_argb_pixel_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_luma,
    input  logic [15:0] i_blue_diff,
    input  logic [15:0] i_red_diff,
    input  logic [15:0] i_alpha_sample,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha_out
);
    import ycta_pkg::*;

    function automatic logic [31:0] fix_quot(input logic [31:0] est, input logic [16:0] nlow,
                                             input logic [15:0] m);
        logic [32:0] prod;
        logic [16:0] rem;
        prod = {16'b0, est[16:0]} * {17'b0, m};
        rem  = nlow - prod[16:0];
        return (rem >= {1'b0, m}) ? est + 32'd1 : est;
    endfunction

    function automatic t_q17 sat17(input logic [31:0] q);
        return (|q[31:17]) ? 17'h1FFFF : q[16:0];
    endfunction

    function automatic t_q17 range_q16(input t_q17 q, input t_coef ks);
        logic [16:0] diff;
        logic [35:0] prod;
        logic [17:0] t;
        diff = (q < FOOT) ? 17'd0 : q - FOOT;
        prod = {19'b0, diff} * {17'b0, ks};
        t    = prod[35:18];
        return (t > {1'b0, ONE_Q16}) ? ONE_Q16 : t[16:0];
    endfunction

    function automatic logic [7:0] chan8(input logic signed [37:0] acc);
        logic signed [19:0] v;
        logic [15:0]        vm;
        logic [7:0]         res;
        v  = acc[37:18];
        vm = v[15:0] - 16'd1;
        if (v[19]) begin
            res = 8'd0;
        end else if (v >= 20'sd65536) begin
            res = 8'hFF;
        end else if (v == 20'sd0) begin
            res = 8'd0;
        end else begin
            res = vm[15:8];
        end
        return res;
    endfunction

    logic [3:0]  r_dsel;
    logic        r_ap;
    logic [15:0] w_m;
    logic [32:0] w_recip;

    assign o_cfg_ready = 1'b1;
    assign w_m         = 16'((17'd2 << r_dsel) - 17'd1);
    assign w_recip     = RECIP[r_dsel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dsel <= DEPTH_SEL_RESET;
            r_ap   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_DEPTH: begin
                    if (i_cfg_data[4:0] == 5'd0) begin
                        r_dsel <= 4'd0;
                    end else if (i_cfg_data[4:0] > 5'd16) begin
                        r_dsel <= DEPTH_SEL_MAX;
                    end else begin
                        r_dsel <= 4'(i_cfg_data[4:0] - 5'd1);
                    end
                end
                CFG_ALPHA_PRESENT: r_ap <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic r_va, r_vb, r_vc, r_vd, r_ve;
    logic w_ena, w_enb, w_enc, w_end, w_ene;

    assign w_ene   = !r_ve || !i_stall;
    assign w_end   = !r_vd || w_ene;
    assign w_enc   = !r_vc || w_end;
    assign w_enb   = !r_vb || w_enc;
    assign w_ena   = !r_va || w_enb;
    assign o_stall = !w_ena;
    assign o_valid = r_ve;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            if (w_ena) r_va <= i_valid;
            if (w_enb) r_vb <= r_va;
            if (w_enc) r_vc <= r_vb;
            if (w_end) r_vd <= r_vc;
            if (w_ene) r_ve <= r_vd;
        end
    end

    // reciprocal estimate of the quotients
    logic [48:0] n_py, n_pcb, n_pcr;
    logic [23:0] n_sa255;
    logic [56:0] n_pa;
    logic [31:0] r_ey, r_ecb, r_ecr;
    logic        r_sy0, r_scb0, r_scr0;
    logic [8:0]  r_ea;
    logic [16:0] r_na;
    logic        r_asat;

    assign n_py    = {33'b0, i_luma} * {16'b0, w_recip};
    assign n_pcb   = {33'b0, i_blue_diff} * {16'b0, w_recip};
    assign n_pcr   = {33'b0, i_red_diff} * {16'b0, w_recip};
    assign n_sa255 = {i_alpha_sample, 8'b0} - {8'b0, i_alpha_sample};
    assign n_pa    = {33'b0, n_sa255} * {24'b0, w_recip};

    always_ff @(posedge i_clk) begin
        if (w_ena) begin
            r_ey   <= n_py[47:16];
            r_ecb  <= n_pcb[47:16];
            r_ecr  <= n_pcr[47:16];
            r_sy0  <= i_luma[0];
            r_scb0 <= i_blue_diff[0];
            r_scr0 <= i_red_diff[0];
            r_ea   <= n_pa[40:32];
            r_na   <= n_sa255[16:0];
            r_asat <= i_alpha_sample > w_m;
        end
    end

    // correct the estimate by one where the remainder allows
    logic [31:0] n_qa;
    logic [7:0]  n_abyte;
    t_q17        r_qy, r_qcb, r_qcr;
    logic [7:0]  r_ab, r_ac, r_ad, r_ae;

    assign n_qa    = fix_quot({23'b0, r_ea}, r_na, w_m);
    assign n_abyte = (!r_ap || r_asat || n_qa[8]) ? 8'hFF : n_qa[7:0];

    always_ff @(posedge i_clk) begin
        if (w_enb) begin
            r_qy  <= sat17(fix_quot(r_ey, {r_sy0, 16'b0}, w_m));
            r_qcb <= sat17(fix_quot(r_ecb, {r_scb0, 16'b0}, w_m));
            r_qcr <= sat17(fix_quot(r_ecr, {r_scr0, 16'b0}, w_m));
            r_ab  <= n_abyte;
        end
    end

    // drop foot and headroom, center chroma
    t_q17               n_tcb, n_tcr;
    t_q17               r_ty;
    logic signed [17:0] r_cb, r_cr;

    assign n_tcb = range_q16(r_qcb, KS_CHROMA);
    assign n_tcr = range_q16(r_qcr, KS_CHROMA);

    always_ff @(posedge i_clk) begin
        if (w_enc) begin
            r_ty <= range_q16(r_qy, KS_LUMA);
            r_cb <= $signed({1'b0, n_tcb}) - $signed({1'b0, HALF_Q16});
            r_cr <= $signed({1'b0, n_tcr}) - $signed({1'b0, HALF_Q16});
            r_ac <= r_ab;
        end
    end

    // matrix products
    t_q17               r_y;
    logic signed [37:0] r_pr, r_pgr, r_pgb, r_pb;

    always_ff @(posedge i_clk) begin
        if (w_end) begin
            r_y   <= r_ty;
            r_pr  <= r_cr * $signed({1'b0, KRV});
            r_pgr <= r_cr * $signed({1'b0, KGR});
            r_pgb <= r_cb * $signed({1'b0, KGB});
            r_pb  <= r_cb * $signed({1'b0, KBU});
            r_ad  <= r_ac;
        end
    end

    // sum, clamp and reduce to 8 bits
    logic signed [37:0] n_base;
    logic [7:0]         r_red, r_green, r_blue;

    assign n_base = $signed({3'b0, r_y, 18'b0});

    always_ff @(posedge i_clk) begin
        if (w_ene) begin
            r_red   <= chan8(n_base + r_pr);
            r_green <= chan8(n_base - r_pgr - r_pgb);
            r_blue  <= chan8(n_base + r_pb);
            r_ae    <= r_ad;
        end
    end

    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_alpha_out = r_ae;

`ifndef NO_ASSERTIONS
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (i_stall && r_va && r_vb && r_vc && r_vd && r_ve))
        else $error("input stalled with an empty stage");

    a_chroma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vd |-> (r_cb >= -18'sd32768 && r_cb <= 18'sd32768
                  && r_cr >= -18'sd32768 && r_cr <= 18'sd32768))
        else $error("centered chroma out of range");

    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vd |-> (r_ty <= ONE_Q16))
        else $error("expanded luma above one");
`endif

endmodule

/* verif/tb_ycbcr_to_argb_pixel_top.sv */
`timescale 1ns / 1ps

module tb_ycbcr_to_argb_pixel_top;

    import ycta_pkg::t_cfg_idx;
    import ycta_pkg::CFG_SAMPLE_DEPTH;
    import ycta_pkg::CFG_ALPHA_PRESENT;

    localparam int      STALL_LIMIT  = 4000;
    localparam int      SETTLE_TICKS = 12;
    localparam int      RAND_PHASES  = 8;
    localparam int      PHASE_PIXELS = 75;

    localparam longint UNIT_Q16    = 65536;
    localparam longint FOOT_LEVEL  = (64'd16 * 64'd65536) / 64'd255;
    localparam longint LUMA_GAIN   = (64'd255 << 18) / 64'd219;
    localparam longint CHROMA_GAIN = (64'd255 << 18) / 64'd224;
    localparam longint CR_TO_R     = ((64'd2 * 64'd7874) << 18) / 64'd10000;
    localparam longint CB_TO_B     = ((64'd2 * 64'd9278) << 18) / 64'd10000;
    localparam longint CR_TO_G     = ((64'd2 * 64'd2126 * 64'd7874) << 18) / 64'd71520000;
    localparam longint CB_TO_G     = ((64'd2 * 64'd722 * 64'd9278) << 18) / 64'd71520000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_argb;

    class argb_scoreboard;
        t_argb      pending_q[$];
        logic [4:0] depth_sel;
        logic       alpha_on;
        int         errors;
        int         checked;

        function new();
            depth_sel = 5'd8;
            alpha_on  = 1'b0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [7:0] data);
            if (idx == CFG_SAMPLE_DEPTH) begin
                depth_sel = data[4:0];
            end else if (idx == CFG_ALPHA_PRESENT) begin
                alpha_on = data[0];
            end
        endfunction

        function longint depth_max();
            int d;
            d = depth_sel;
            if (d < 1) begin
                d = 1;
            end
            if (d > 16) begin
                d = 16;
            end
            return (longint'(1) << d) - 1;
        endfunction

        function longint expand_q16(logic [15:0] s, longint maxv, longint gain);
            longint n;
            longint t;
            n = (longint'(s) * UNIT_Q16) / maxv;
            if (n < FOOT_LEVEL) begin
                return 0;
            end
            t = ((n - FOOT_LEVEL) * gain) >>> 18;
            return (t > UNIT_Q16) ? UNIT_Q16 : t;
        endfunction

        function logic [7:0] to_byte(longint acc);
            longint v;
            v = acc >>> 18;
            if (v < 0) begin
                v = 0;
            end
            if (v > UNIT_Q16) begin
                v = UNIT_Q16;
            end
            return 8'(((v * 65535) >> 16) >> 8);
        endfunction

        function void note_pixel(logic [15:0] y, logic [15:0] cb, logic [15:0] cr,
                                 logic [15:0] a);
            longint maxv;
            longint yq;
            longint cbq;
            longint crq;
            longint base;
            longint av;
            t_argb  px;
            maxv = depth_max();
            yq   = expand_q16(y, maxv, LUMA_GAIN);
            cbq  = expand_q16(cb, maxv, CHROMA_GAIN) - UNIT_Q16 / 2;
            crq  = expand_q16(cr, maxv, CHROMA_GAIN) - UNIT_Q16 / 2;
            base = yq * 262144;
            px.red   = to_byte(base + crq * CR_TO_R);
            px.green = to_byte(base - crq * CR_TO_G - cbq * CB_TO_G);
            px.blue  = to_byte(base + cbq * CB_TO_B);
            if (alpha_on) begin
                av = (longint'(a) * 255) / maxv;
                px.alpha = (av > 255) ? 8'd255 : 8'(av);
            end else begin
                px.alpha = 8'd255;
            end
            pending_q.push_back(px);
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                  logic [7:0] a);
            t_argb px;
            if (pending_q.size() == 0) begin
                $error("unexpected output transaction: r %0d g %0d b %0d a %0d", r, g, b, a);
                errors++;
                return;
            end
            px = pending_q.pop_front();
            compare_field("red", px.red, r);
            compare_field("green", px.green, g);
            compare_field("blue", px.blue, b);
            compare_field("alpha_out", px.alpha, a);
            checked++;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_luma;
    logic [15:0] i_blue_diff;
    logic [15:0] i_red_diff;
    logic [15:0] i_alpha_sample;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha_out;

    argb_scoreboard sb = new();

    int idle_pct;
    int stall_pct;
    int quiet_ticks;
    int cfg_writes;
    int cur_max;

    ycbcr_to_argb_pixel_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_luma         (i_luma),
        .i_blue_diff    (i_blue_diff),
        .i_red_diff     (i_red_diff),
        .i_alpha_sample (i_alpha_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha_out    (o_alpha_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_pixel(o_red, o_green, o_blue, o_alpha_out);
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_ticks <= 0;
        end else if (quiet_ticks + 1 >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("tb_ycbcr_to_argb_pixel_top: done, errors");
            $finish;
        end else begin
            quiet_ticks <= quiet_ticks + 1;
        end
    end

    task automatic send_pixel(input logic [15:0] y, input logic [15:0] cb,
                              input logic [15:0] cr, input logic [15:0] a);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_luma         <= y;
        i_blue_diff    <= cb;
        i_red_diff     <= cr;
        i_alpha_sample <= a;
        do @(posedge i_clk); while (o_stall);
        sb.note_pixel(y, cb, cr, a);
    endtask

    // drop valid and wait for the pipeline to empty before touching registers
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [7:0] depth_data, input logic [7:0] alpha_data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SAMPLE_DEPTH;
        i_cfg_data  <= depth_data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(CFG_SAMPLE_DEPTH, depth_data);
        i_cfg_index <= CFG_ALPHA_PRESENT;
        i_cfg_data  <= alpha_data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(CFG_ALPHA_PRESENT, alpha_data);
        i_cfg_valid <= 1'b0;
        cfg_writes += 2;
        cur_max = int'(sb.depth_max());
        repeat (2) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample(int maxv);
        case ($urandom_range(19))
            0:       return 16'($urandom);
            1:       return 16'd0;
            2:       return 16'(maxv);
            3:       return 16'((maxv * 16) / 255);
            4:       return 16'((maxv * 235) / 255);
            5:       return 16'((maxv * 240) / 255);
            default: return 16'($urandom_range(maxv));
        endcase
    endfunction

    initial begin
        int depth_list [RAND_PHASES] = '{8, 16, 1, 12, 0, 31, 5, 10};
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_SAMPLE_DEPTH;
        i_cfg_data     <= 8'd0;
        i_valid        <= 1'b0;
        i_luma         <= 16'd0;
        i_blue_diff    <= 16'd0;
        i_red_diff     <= 16'd0;
        i_alpha_sample <= 16'd0;
        i_stall        <= 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        quiet_ticks = 0;
        cfg_writes  = 0;
        cur_max     = 255;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: 8-bit samples, alpha forced opaque
        send_pixel(16'd0, 16'd0, 16'd0, 16'd0);
        send_pixel(16'd16, 16'd128, 16'd128, 16'd77);
        send_pixel(16'd235, 16'd128, 16'd128, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'd81, 16'd90, 16'd240, 16'd200);
        send_pixel(16'd235, 16'd16, 16'd16, 16'd1);
        send_pixel(16'd235, 16'd240, 16'd240, 16'd255);
        drain_pipeline();

        write_settings(8'd16, 8'd1);
        send_pixel(16'd0, 16'd0, 16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hEB00, 16'h8000, 16'h8000, 16'h8000);
        send_pixel(16'h1000, 16'hF000, 16'h1000, 16'd1);
        drain_pipeline();

        write_settings(8'd1, 8'd1);
        send_pixel(16'd0, 16'd0, 16'd0, 16'd0);
        send_pixel(16'd1, 16'd1, 16'd1, 16'd1);
        send_pixel(16'd1, 16'd0, 16'd0, 16'd1);
        send_pixel(16'd2, 16'd3, 16'd0, 16'd2);
        drain_pipeline();

        write_settings(8'hE0, 8'hFE);
        send_pixel(16'd1, 16'd1, 16'd0, 16'd1);
        send_pixel(16'hFFFF, 16'h5555, 16'hAAAA, 16'hFFFF);
        drain_pipeline();

        write_settings(8'd31, 8'd1);
        send_pixel(16'h8000, 16'h7FFF, 16'h8001, 16'h8000);
        send_pixel(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
        drain_pipeline();

        write_settings(8'd10, 8'd1);
        send_pixel(16'd1023, 16'd512, 16'd512, 16'd1023);
        send_pixel(16'd1024, 16'd1500, 16'd2000, 16'd1500);
        drain_pipeline();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_settings({3'($urandom), 5'(depth_list[ph])}, {7'($urandom), 1'(ph % 2)});
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 66; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 66; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            for (int k = 0; k < PHASE_PIXELS; k++) begin
                send_pixel(pick_sample(cur_max), pick_sample(cur_max),
                           pick_sample(cur_max), pick_sample(cur_max));
            end
            drain_pipeline();
            idle_pct  = 0;
            stall_pct = 0;
        end

        if (sb.pending_q.size() != 0) begin
            $error("%0d expected pixels never arrived", sb.pending_q.size());
            sb.errors += sb.pending_q.size();
        end
        $display("checked %0d ARGB pixels over %0d register writes", sb.checked, cfg_writes);
        $display("depths 0..31 incl. out-of-range, alpha on/off, free-running and stalled pacing");
        if (sb.errors == 0) begin
            $display("tb_ycbcr_to_argb_pixel_top: done, clean");
        end else begin
            $display("tb_ycbcr_to_argb_pixel_top: done, errors");
        end
        $finish;
    end

endmodule
